[hw/rtl/htb_pkg.sv]
`default_nettype none

package htb_pkg;

  // Character codes that steer the parser.
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRICT_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAW_CHARS   = 1'b1;

  // Error kinds reported in an error result.
  localparam logic [2:0] ERR_SEP_AFTER_UNDELIM = 3'd0;
  localparam logic [2:0] ERR_MIXED_SEPARATORS  = 3'd1;
  localparam logic [2:0] ERR_MISSING_SEPARATOR = 3'd2;
  localparam logic [2:0] ERR_EMPTY_BYTE        = 3'd3;
  localparam logic [2:0] ERR_NON_HEX           = 3'd4;
  localparam logic [2:0] ERR_NONE_KIND         = 3'd0;

  // Default depth of the queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    STYLE_UNKNOWN = 2'd0,
    STYLE_NONE    = 2'd1,
    STYLE_COLON   = 2'd2,
    STYLE_SPACE   = 2'd3
  } sep_style_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_error;
    logic [2:0] error_kind;
    logic       last_of_run;
  } out_item_t;

  // All results caused by one item: one or two of them.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } run_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_status_t;

endpackage

`default_nettype wire

[hw/rtl/hex_text_to_bytes_parser.sv]
`default_nettype none

// Hex text to bytes parser.
// The input channel (in_valid, in_stall, in_data) carries one character per item together
// with an end-of-string mark. The result channel (out_valid, out_stall, out_data) carries
// parsed bytes and error reports; the final result caused by an item has last_of_run set.
// An item may cause no result, one, or two (a closed byte followed by an error or by the
// flushed final byte). The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_wdata) writes strict_mode (index 0) and raw_chars (index 1); cfg_ready is always high.
// The results of an item pass through the queue and then through the output register.
// Throughput: one item per cycle while items cause at most one result and out_stall is
// low; an item with two results holds the output register for each of them in turn. The
// output register, which hands out one result per cycle unless stalled, sets that rate.
// A queue of QUEUE_DEPTH runs sits between the parsing front end and the output stage, so
// the input keeps taking items while the receiver stalls until that queue is full; in_stall
// then rises. Results are held unchanged while out_stall is high.
// After reset: strict mode on, raw mode off, parse state cleared, no results pending.
module hex_text_to_bytes_parser #(
  parameter int unsigned QUEUE_DEPTH = htb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire htb_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output htb_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [htb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic                            cfg_wdata
);

  logic               accept;
  logic               push;
  logic               pop;
  htb_pkg::run_t      push_run;
  htb_pkg::run_t      head;
  htb_pkg::q_status_t q_status;

  // Registers can always be written; the user only writes them while the block is idle.
  assign cfg_ready = 1'b1;

  // The front end stalls only on a full queue, never on the receiver directly.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // Front end: classifies each character, updates the parse state and forms its results.
  htb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .push      (push),
    .run       (push_run)
  );

  // Queue of result runs between the two ends.
  htb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: hands out each run's results one per cycle unless stalled (output register).
  htb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hw/rtl/htb_front.sv]
`default_nettype none

module htb_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [htb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic                              cfg_wdata,
  input  wire logic                              accept,
  input  wire htb_pkg::in_item_t                 item,
  output logic                                   push,
  output htb_pkg::run_t                          run
);

  logic                strict_r;
  logic                raw_r;
  logic [7:0]          partial_byte_r;
  logic [7:0]          partial_byte_nxt;
  logic [1:0]          digit_count_r;
  logic [1:0]          digit_count_nxt;
  htb_pkg::sep_style_t style_r;
  htb_pkg::sep_style_t style_nxt;
  logic                discarding_r;
  logic                discarding_nxt;

  logic                is_sep;
  htb_pkg::sep_style_t sep_code;
  logic                hex_ok;
  logic [3:0]          hex_val;
  logic                err_hit;
  logic [2:0]          err_kind;
  logic                byte_hit;
  logic [7:0]          byte_val;
  logic                sec_hit;
  htb_pkg::out_item_t  byte_res;
  htb_pkg::out_item_t  sec_res;

  function automatic logic hex_digit_ok(input logic [7:0] c);
    hex_digit_ok = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_digit_val(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      hex_digit_val = c[3:0];
    end else begin
      // Letters A-F and a-f both have 1..6 in the low nibble.
      hex_digit_val = 4'(c[3:0] + 4'd9);
    end
  endfunction

  always_comb begin
    partial_byte_nxt = partial_byte_r;
    digit_count_nxt  = digit_count_r;
    style_nxt        = style_r;
    discarding_nxt   = discarding_r;
    err_hit          = 1'b0;
    err_kind         = htb_pkg::ERR_NONE_KIND;
    byte_hit         = 1'b0;
    byte_val         = partial_byte_r;
    sec_hit          = 1'b0;
    sec_res          = '0;
    is_sep   = (item.text_char == htb_pkg::CHAR_COLON) ||
               (item.text_char == htb_pkg::CHAR_SPACE);
    sep_code = (item.text_char == htb_pkg::CHAR_COLON) ? htb_pkg::STYLE_COLON
                                                       : htb_pkg::STYLE_SPACE;
    hex_ok   = hex_digit_ok(item.text_char);
    hex_val  = hex_digit_val(item.text_char);

    if (raw_r) begin
      byte_hit = 1'b1;
      byte_val = item.text_char;
      if (item.end_of_string) begin
        partial_byte_nxt = '0;
        digit_count_nxt  = '0;
        style_nxt        = htb_pkg::STYLE_UNKNOWN;
        discarding_nxt   = 1'b0;
      end
    end else if (discarding_r) begin
      if (item.end_of_string) begin
        partial_byte_nxt = '0;
        digit_count_nxt  = '0;
        style_nxt        = htb_pkg::STYLE_UNKNOWN;
        discarding_nxt   = 1'b0;
      end
    end else begin
      // A separator, or any character after two digits, closes the byte.
      if ((digit_count_r == 2'd2) || is_sep) begin
        if (is_sep) begin
          if (style_r == htb_pkg::STYLE_UNKNOWN) begin
            style_nxt = sep_code;
          end else if (style_r == htb_pkg::STYLE_NONE) begin
            if (strict_r) begin
              err_hit  = 1'b1;
              err_kind = htb_pkg::ERR_SEP_AFTER_UNDELIM;
            end
          end else if (style_r != sep_code) begin
            if (strict_r) begin
              err_hit  = 1'b1;
              err_kind = htb_pkg::ERR_MIXED_SEPARATORS;
            end
          end
        end else begin
          if (((style_r == htb_pkg::STYLE_COLON) || (style_r == htb_pkg::STYLE_SPACE)) &&
              strict_r) begin
            err_hit  = 1'b1;
            err_kind = htb_pkg::ERR_MISSING_SEPARATOR;
          end else begin
            style_nxt = htb_pkg::STYLE_NONE;
          end
        end
        if (!err_hit) begin
          if (digit_count_r == 2'd0) begin
            if (strict_r) begin
              err_hit  = 1'b1;
              err_kind = htb_pkg::ERR_EMPTY_BYTE;
            end
          end else begin
            byte_hit = 1'b1;
            byte_val = partial_byte_r;
          end
          if (!err_hit) begin
            partial_byte_nxt = '0;
            digit_count_nxt  = '0;
          end
        end
      end

      if (!err_hit && !is_sep) begin
        if (!hex_ok) begin
          if (strict_r) begin
            err_hit  = 1'b1;
            err_kind = htb_pkg::ERR_NON_HEX;
          end
        end else begin
          partial_byte_nxt = {partial_byte_nxt[3:0], hex_val};
          digit_count_nxt  = 2'(digit_count_nxt + 2'd1);
        end
      end

      if (err_hit) begin
        sec_hit            = 1'b1;
        sec_res.is_error   = 1'b1;
        sec_res.error_kind = err_kind;
        if (item.end_of_string) begin
          partial_byte_nxt = '0;
          digit_count_nxt  = '0;
          style_nxt        = htb_pkg::STYLE_UNKNOWN;
          discarding_nxt   = 1'b0;
        end else begin
          discarding_nxt = 1'b1;
        end
      end else if (item.end_of_string) begin
        if (digit_count_nxt != 2'd0) begin
          sec_hit          = 1'b1;
          sec_res.out_byte = partial_byte_nxt;
        end
        partial_byte_nxt = '0;
        digit_count_nxt  = '0;
        style_nxt        = htb_pkg::STYLE_UNKNOWN;
        discarding_nxt   = 1'b0;
      end
    end

    byte_res             = '0;
    byte_res.out_byte    = byte_val;
    byte_res.error_kind  = htb_pkg::ERR_NONE_KIND;
    sec_res.last_of_run  = 1'b1;

    run.two              = byte_hit && sec_hit;
    run.first            = byte_hit ? byte_res : sec_res;
    run.first.last_of_run = !(byte_hit && sec_hit);
    run.second           = sec_res;
    push                 = accept && (byte_hit || sec_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r       <= 1'b1;
      raw_r          <= 1'b0;
      partial_byte_r <= '0;
      digit_count_r  <= '0;
      style_r        <= htb_pkg::STYLE_UNKNOWN;
      discarding_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          htb_pkg::CFG_STRICT_MODE: strict_r <= cfg_wdata;
          htb_pkg::CFG_RAW_CHARS:   raw_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        partial_byte_r <= partial_byte_nxt;
        digit_count_r  <= digit_count_nxt;
        style_r        <= style_nxt;
        discarding_r   <= discarding_nxt;
      end
    end
  end

  a_digit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r != 2'd3)
    else $error("digit count left its range");

endmodule

`default_nettype wire

[hw/rtl/htb_queue.sv]
`default_nettype none

module htb_queue #(
  parameter int unsigned DEPTH = htb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire htb_pkg::run_t push_run,
  input  wire logic          pop,
  output htb_pkg::run_t      head,
  output htb_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  htb_pkg::run_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
    head         = slot_r[rd_ptr_r];
    status.full  = (count_r == CNT_W'(DEPTH));
    status.avail = (count_r != '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && count_r == CNT_W'(DEPTH) && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && count_r == '0))
    else $error("queue read while empty");

endmodule

`default_nettype wire

[hw/rtl/htb_back.sv]
`default_nettype none

module htb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire htb_pkg::run_t      head,
  input  wire htb_pkg::q_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output htb_pkg::out_item_t      out_data
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  htb_pkg::out_item_t out_data_r;
  logic               idx_r;
  logic               idx_nxt;
  logic               load;

  always_comb begin
    load          = status.avail && (!out_valid_r || !out_stall);
    pop           = load && (idx_r || !head.two);
    idx_nxt       = load ? !pop : idx_r;
    out_valid_nxt = (!out_valid_r || !out_stall) ? status.avail : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= idx_r ? head.second : head.first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> (status.avail && head.two))
    else $error("second result selected without a two-result run at the head");

endmodule

`default_nettype wire
